// ===== hdl/line_rasterizer_core_macros.svh =====
// Assertion helpers for the line rasterizer checker.
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define LRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define LRC_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrc_pkg.sv =====
package lrc_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int CFG_W          = 7;
    localparam int COLOR_W        = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CMD_DEPTH      = 4;

    localparam logic [CFG_W-1:0] IMG_SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    // line classification handed from front to walker
    typedef struct packed {
        logic x_major;
        logic step_neg;
    } t_cls;

endpackage

// ===== hdl/line_rasterizer_core.sv =====
// Bresenham line rasterizer. Each command (two endpoints and a color) is
// walked along its major axis, one pixel per cycle, from the lower endpoint
// up to but not including the higher one; a zero-length line yields no
// pixels. The front stage classifies a command and parks it in a
// four-entry command queue, so commands keep flowing in while a line
// is being drawn. In the walker a line first loads its command, then
// yields one pixel per cycle, limited by the single error-term update per
// step; pops held low stall the walk.
// image_width and image_height only set the visible flag; they should be
// written while no line is in flight.
module line_rasterizer_core #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [COORD_BITS-1:0]         i_start_x,
    input  logic [COORD_BITS-1:0]         i_start_y,
    input  logic [COORD_BITS-1:0]         i_end_x,
    input  logic [COORD_BITS-1:0]         i_end_y,
    input  logic [lrc_pkg::COLOR_W-1:0]   i_red_in,
    input  logic [lrc_pkg::COLOR_W-1:0]   i_green_in,
    input  logic [lrc_pkg::COLOR_W-1:0]   i_blue_in,
    input  logic                          i_cfg_we,
    input  logic [lrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lrc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [lrc_pkg::COLOR_W-1:0]   o_pixel_red,
    output logic [lrc_pkg::COLOR_W-1:0]   o_pixel_green,
    output logic [lrc_pkg::COLOR_W-1:0]   o_pixel_blue,
    output logic                          o_visible,
    output logic                          o_last_pixel
);
    import lrc_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int CMD_W = $bits(t_cls) + 5 * CB + $bits(t_color);

    logic [CFG_W-1:0] r_image_width, r_image_height;

    t_color           in_color, f_color, w_color, out_color;
    t_cls             f_cls, w_cls;
    logic [CB-1:0]    f_maj0, f_maj1, f_min0, f_dmaj, f_dmin;
    logic [CB-1:0]    w_maj0, w_maj1, w_min0, w_dmaj, w_dmin;
    logic             f_valid, q_full, q_empty, w_take;
    logic [CMD_W-1:0] q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMG_SIZE_RESET;
            r_image_height <= IMG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_color = '{red: i_red_in, green: i_green_in, blue: i_blue_in};

    lrc_front #(.COORD_BITS(CB)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_color   (in_color),
        .o_valid   (f_valid),
        .i_ready   (!q_full),
        .o_cls     (f_cls),
        .o_maj0    (f_maj0),
        .o_maj1    (f_maj1),
        .o_min0    (f_min0),
        .o_dmaj    (f_dmaj),
        .o_dmin    (f_dmin),
        .o_color   (f_color)
    );

    assign q_wdata = {f_cls, f_maj0, f_maj1, f_min0, f_dmaj, f_dmin, f_color};

    lrc_cmd_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .o_full  (q_full),
        .i_data  (q_wdata),
        .i_rd    (w_take),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign {w_cls, w_maj0, w_maj1, w_min0, w_dmaj, w_dmin, w_color} = q_rdata;

    lrc_walker #(.COORD_BITS(CB)) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .o_cmd_take     (w_take),
        .i_cls          (w_cls),
        .i_maj0         (w_maj0),
        .i_maj1         (w_maj1),
        .i_min0         (w_min0),
        .i_dmaj         (w_dmaj),
        .i_dmin         (w_dmin),
        .i_color        (w_color),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_color        (out_color),
        .o_visible      (o_visible),
        .o_last_pixel   (o_last_pixel)
    );

    assign o_pixel_red   = out_color.red;
    assign o_pixel_green = out_color.green;
    assign o_pixel_blue  = out_color.blue;

endmodule

// ===== hdl/lrc_front.sv =====
module lrc_front #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  lrc_pkg::t_color       i_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output lrc_pkg::t_cls         o_cls,
    output logic [COORD_BITS-1:0] o_maj0,
    output logic [COORD_BITS-1:0] o_maj1,
    output logic [COORD_BITS-1:0] o_min0,
    output logic [COORD_BITS-1:0] o_dmaj,
    output logic [COORD_BITS-1:0] o_dmin,
    output lrc_pkg::t_color       o_color
);
    import lrc_pkg::*;

    localparam int CB = COORD_BITS;

    logic signed [CB:0] dx, dy, dm;
    logic [CB-1:0]      ax, ay, maj0, maj1, min0, min1, dmaj, dmin;
    logic               x_major, accept;

    logic               r_valid;
    t_cls               r_cls;
    logic [CB-1:0]      r_maj0, r_maj1, r_min0, r_dmaj, r_dmin;
    t_color             r_color;

    always_comb begin
        dx = $signed({1'b0, i_end_x}) - $signed({1'b0, i_start_x});
        dy = $signed({1'b0, i_end_y}) - $signed({1'b0, i_start_y});
        ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        x_major = ay < ax;
        if (x_major) begin
            if (!dx[CB]) begin
                maj0 = i_start_x; maj1 = i_end_x; min0 = i_start_y; min1 = i_end_y;
            end else begin
                maj0 = i_end_x; maj1 = i_start_x; min0 = i_end_y; min1 = i_start_y;
            end
        end else begin
            if (!dy[CB]) begin
                maj0 = i_start_y; maj1 = i_end_y; min0 = i_start_x; min1 = i_end_x;
            end else begin
                maj0 = i_end_y; maj1 = i_start_y; min0 = i_end_x; min1 = i_start_x;
            end
        end
        dmaj = maj1 - maj0;
        dm   = $signed({1'b0, min1}) - $signed({1'b0, min0});
        dmin = dm[CB] ? CB'(-dm) : dm[CB-1:0];
    end

    assign o_full = r_valid && !i_ready;
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            // zero-length lines are dropped here
            r_valid <= accept && (dmaj != '0);
        end
        if (accept) begin
            r_cls.x_major  <= x_major;
            r_cls.step_neg <= dm[CB];
            r_maj0  <= maj0;
            r_maj1  <= maj1;
            r_min0  <= min0;
            r_dmaj  <= dmaj;
            r_dmin  <= dmin;
            r_color <= i_color;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign o_maj0  = r_maj0;
    assign o_maj1  = r_maj1;
    assign o_min0  = r_min0;
    assign o_dmaj  = r_dmaj;
    assign o_dmin  = r_dmin;
    assign o_color = r_color;

endmodule

// ===== hdl/lrc_cmd_fifo.sv =====
module lrc_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lrc_pkg::CMD_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/lrc_walker.sv =====
module lrc_walker #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_take,
    input  lrc_pkg::t_cls             i_cls,
    input  logic [COORD_BITS-1:0]     i_maj0,
    input  logic [COORD_BITS-1:0]     i_maj1,
    input  logic [COORD_BITS-1:0]     i_min0,
    input  logic [COORD_BITS-1:0]     i_dmaj,
    input  logic [COORD_BITS-1:0]     i_dmin,
    input  lrc_pkg::t_color           i_color,
    input  logic [lrc_pkg::CFG_W-1:0] i_image_width,
    input  logic [lrc_pkg::CFG_W-1:0] i_image_height,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [COORD_BITS-1:0]     o_pixel_x,
    output logic [COORD_BITS-1:0]     o_pixel_y,
    output lrc_pkg::t_color           o_color,
    output logic                      o_visible,
    output logic                      o_last_pixel
);
    import lrc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EW = CB + 3;
    localparam int VW = (CB > CFG_W) ? CB : CFG_W;

    logic                 r_busy;
    t_cls                 r_cls;
    logic [CB-1:0]        r_maj, r_maj1, r_min;
    logic signed [EW-1:0] r_err, r_dmaj2, r_dmin2;
    t_color               r_color;

    logic                 r_out_valid;
    logic [CB-1:0]        r_px, r_py;
    t_color               r_out_color;
    logic                 r_vis, r_last;

    logic                 advance, last;
    logic [CB-1:0]        cur_x, cur_y;
    logic signed [EW-1:0] in_dmin2, in_dmaj;
    logic signed [EW-1:0] n_err;
    logic [CB-1:0]        n_min;

    assign o_cmd_take = !r_busy && i_cmd_valid;
    assign advance    = r_busy && (!r_out_valid || i_pop);
    assign last       = ({1'b0, r_maj} + 1'b1) == {1'b0, r_maj1};
    assign cur_x      = r_cls.x_major ? r_maj : r_min;
    assign cur_y      = r_cls.x_major ? r_min : r_maj;
    assign in_dmin2   = $signed({2'b00, i_dmin, 1'b0});
    assign in_dmaj    = $signed({3'b000, i_dmaj});

    always_comb begin
        n_err = r_err + r_dmin2;
        n_min = r_min;
        if (r_err > 0) begin
            n_err = r_err - r_dmaj2 + r_dmin2;
            n_min = r_cls.step_neg ? r_min - 1'b1 : r_min + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_busy <= 1'b1;
            end else if (advance && last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_cmd_take) begin
            r_cls   <= i_cls;
            r_maj   <= i_maj0;
            r_maj1  <= i_maj1;
            r_min   <= i_min0;
            r_err   <= in_dmin2 - in_dmaj;
            r_dmaj2 <= $signed({2'b00, i_dmaj, 1'b0});
            r_dmin2 <= in_dmin2;
            r_color <= i_color;
        end else if (advance) begin
            r_maj <= r_maj + 1'b1;
            r_min <= n_min;
            r_err <= n_err;
        end
        if (advance) begin
            r_px        <= cur_x;
            r_py        <= cur_y;
            r_out_color <= r_color;
            r_vis       <= (VW'(cur_x) < VW'(i_image_width)) &&
                           (VW'(cur_y) < VW'(i_image_height));
            r_last      <= last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_color      = r_out_color;
    assign o_visible    = r_vis;
    assign o_last_pixel = r_last;

endmodule

// ===== hdl/lrc_checker.sv =====
`include "line_rasterizer_core_macros.svh"

module lrc_checker #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [COORD_BITS-1:0]         o_pixel_x,
    input logic [COORD_BITS-1:0]         o_pixel_y,
    input logic [lrc_pkg::COLOR_W-1:0]   o_pixel_red,
    input logic [lrc_pkg::COLOR_W-1:0]   o_pixel_green,
    input logic [lrc_pkg::COLOR_W-1:0]   o_pixel_blue,
    input logic                          o_visible,
    input logic                          o_last_pixel
);
    import lrc_pkg::*;

    logic [2*COORD_BITS+1:0] pix_bits;
    logic [3*COLOR_W-1:0]    color_bits;

    assign pix_bits   = {o_pixel_x, o_pixel_y, o_visible, o_last_pixel};
    assign color_bits = {o_pixel_red, o_pixel_green, o_pixel_blue};

    // nothing to show right after reset
    `LRC_ASSERT_RST(a_reset_empty, !i_rst_n, empty && !full, "output not empty after reset")

    // a pixel that is not taken holds
    `LRC_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(pix_bits), "held pixel changed")

    // inside a line the next pixel follows without a gap
    `LRC_ASSERT_NXT(a_no_gap, !empty && pop && !o_last_pixel, !empty, "gap inside a line")

    // the color stays the same along a line
    `LRC_ASSERT_NXT(a_color, !empty && pop && !o_last_pixel, $stable(color_bits), "color changed")

endmodule

bind line_rasterizer_core lrc_checker #(.COORD_BITS(COORD_BITS)) u_lrc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lrc_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_GUARD = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 7;
    localparam int LINES_PER_PHASE = 33;

    typedef struct packed {
        logic [CW-1:0]      x;
        logic [CW-1:0]      y;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               vis;
        logic               last;
    } t_pixel;

    typedef enum int {RX_STREAM, RX_SPARSE, RX_PATTERN, RX_COIN} t_rx_mode;

    class line_scoreboard;
        t_pixel          pix_q[$];
        logic [CFG_W-1:0] img_w = IMG_SIZE_RESET;
        logic [CFG_W-1:0] img_h = IMG_SIZE_RESET;
        int errors;
        int lines;
        int checked;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_IMAGE_WIDTH)
                img_w = val;
            else if (idx == CFG_IMAGE_HEIGHT)
                img_h = val;
        endfunction

        function int pending();
            return pix_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Bresenham walk along the major axis, far endpoint excluded
        function void note_line(int x0, int y0, int x1, int y1,
                                logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                logic [COLOR_W-1:0] b);
            int sx, sy, maj0, maj1, min0, min1, dmaj, dmin, stp, err, mn;
            bit xmaj;
            t_pixel p;
            sx = x1 - x0;
            sy = y1 - y0;
            xmaj = (sy * sy) < (sx * sx);
            if (xmaj) begin
                if (x0 <= x1) begin
                    maj0 = x0; maj1 = x1; min0 = y0; min1 = y1;
                end else begin
                    maj0 = x1; maj1 = x0; min0 = y1; min1 = y0;
                end
            end else begin
                if (y0 <= y1) begin
                    maj0 = y0; maj1 = y1; min0 = x0; min1 = x1;
                end else begin
                    maj0 = y1; maj1 = y0; min0 = x1; min1 = x0;
                end
            end
            dmaj = maj1 - maj0;
            dmin = min1 - min0;
            stp = 1;
            if (dmin < 0) begin
                stp = -1;
                dmin = -dmin;
            end
            err = 2 * dmin - dmaj;
            mn = min0;
            for (int i = maj0; i < maj1; i++) begin
                p.x = CW'(xmaj ? i : mn);
                p.y = CW'(xmaj ? mn : i);
                p.r = r;
                p.g = g;
                p.b = b;
                p.vis = ({1'b0, p.x} < img_w) && ({1'b0, p.y} < img_h);
                p.last = (i == maj1 - 1);
                pix_q = {pix_q, p};
                if (err > 0) begin
                    mn += stp;
                    err -= 2 * dmaj;
                end
                err += 2 * dmin;
            end
            lines++;
        endfunction

        task cmp(string name, logic [7:0] got_v, logic [7:0] want_v);
            if (got_v !== want_v)
                report($sformatf("pixel %0d %s: got %0h want %0h", checked, name,
                                 got_v, want_v));
        endtask

        task check_pixel(t_pixel got);
            t_pixel want;
            if (pix_q.size() == 0) begin
                report($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
                return;
            end
            want = pix_q.pop_front();
            cmp("x", got.x, want.x);
            cmp("y", got.y, want.y);
            cmp("red", got.r, want.r);
            cmp("green", got.g, want.g);
            cmp("blue", got.b, want.b);
            cmp("visible", got.vis, want.vis);
            cmp("last", got.last, want.last);
            checked++;
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [CW-1:0]      i_start_x, i_start_y, i_end_x, i_end_y;
    logic [COLOR_W-1:0] i_red_in, i_green_in, i_blue_in;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               empty;
    logic               pop;
    logic [CW-1:0]      o_pixel_x, o_pixel_y;
    logic [COLOR_W-1:0] o_pixel_red, o_pixel_green, o_pixel_blue;
    logic               o_visible;
    logic               o_last_pixel;

    line_scoreboard sb = new();
    int hold_left = 0;
    int in_stalls = 0;
    int settings = 1;

    line_rasterizer_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_red  (o_pixel_red),
        .o_pixel_green(o_pixel_green),
        .o_pixel_blue (o_pixel_blue),
        .o_visible    (o_visible),
        .o_last_pixel (o_last_pixel)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                sb.note_line(i_start_x, i_start_y, i_end_x, i_end_y,
                             i_red_in, i_green_in, i_blue_in);
            if (push && full)
                in_stalls++;
            if (pop && !empty)
                sb.check_pixel(t_pixel'{o_pixel_x, o_pixel_y, o_pixel_red,
                                        o_pixel_green, o_pixel_blue, o_visible,
                                        o_last_pixel});
        end
    end

    // result side: random stall modes, plus a long hold-off on request
    initial begin
        t_rx_mode rx_mode;
        int mode_left;
        logic [15:0] rx_pat;
        rx_mode = RX_STREAM;
        mode_left = 0;
        rx_pat = 16'b1101_0011_1000_1110;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_STREAM: pop <= 1'b1;
                    RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                    RX_PATTERN: begin
                        pop <= rx_pat[0];
                        rx_pat = {rx_pat[0], rx_pat[15:1]};
                    end
                    default: pop <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    task send_line(input logic [CW-1:0] x0, input logic [CW-1:0] y0,
                   input logic [CW-1:0] x1, input logic [CW-1:0] y1,
                   input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                   input logic [COLOR_W-1:0] b);
        @(negedge i_clk);
        push <= 1'b1;
        i_start_x <= x0;
        i_start_y <= y0;
        i_end_x <= x1;
        i_end_y <= y1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        do @(posedge i_clk); while (full !== 1'b0);
    endtask

    task idle_input(int n);
        if (n > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stop sending until every predicted pixel is out, then let the queue settle
    task drain_pixels();
        int guard;
        guard = 0;
        idle_input(1);
        while (sb.pending() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d pixels never arrived", sb.pending()));
            sb.pix_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function int near(int c);
        int v;
        v = c + $urandom_range(0, 6) - 3;
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    task random_line();
        int kind;
        logic [CW-1:0] x0, y0, x1, y1;
        logic [COLOR_W-1:0] r, g, b;
        kind = $urandom_range(0, 9);
        x0 = CW'($urandom_range(0, 63));
        y0 = CW'($urandom_range(0, 63));
        r = COLOR_W'($urandom);
        g = COLOR_W'($urandom);
        b = COLOR_W'($urandom);
        if (kind == 0) begin
            x1 = x0;
            y1 = y0;
        end else if (kind <= 3) begin
            x1 = CW'(near(x0));
            y1 = CW'(near(y0));
        end else begin
            x1 = CW'($urandom);
            y1 = CW'($urandom);
        end
        send_line(x0, y0, x1, y1, r, g, b);
    endtask

    initial begin
        int w_set[PHASES];
        int h_set[PHASES];
        int sent, burst;
        w_set = '{0, 64, 1, 127, 65, 40, 0};
        h_set = '{64, 0, 1, 127, 100, 23, 0};
        i_rst_n = 1'b0;
        push = 1'b0;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        i_red_in = '0;
        i_green_in = '0;
        i_blue_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines at reset sizes
        send_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00);
        send_line(63, 63, 63, 63, 8'hff, 8'hff, 8'hff);
        send_line(0, 0, 63, 0, 8'hff, 8'h00, 8'haa);
        send_line(63, 63, 0, 63, 8'h00, 8'hff, 8'h55);
        send_line(0, 0, 0, 63, 8'haa, 8'h55, 8'hff);
        send_line(63, 63, 63, 0, 8'h55, 8'haa, 8'h00);
        send_line(0, 0, 63, 63, 8'h12, 8'h34, 8'h56);
        send_line(63, 0, 0, 63, 8'h80, 8'h01, 8'h7f);
        send_line(0, 63, 63, 0, 8'h01, 8'h80, 8'hfe);
        send_line(10, 10, 11, 10, 8'h0f, 8'hf0, 8'h3c);
        send_line(10, 10, 10, 11, 8'hf0, 8'h0f, 8'hc3);
        send_line(10, 10, 11, 11, 8'h33, 8'hcc, 8'h99);
        send_line(0, 20, 63, 40, 8'h66, 8'h99, 8'h33);
        send_line(63, 20, 0, 40, 8'h11, 8'h22, 8'h44);
        send_line(5, 60, 50, 2, 8'h88, 8'h77, 8'hee);
        send_line(20, 0, 40, 63, 8'h5a, 8'ha5, 8'h69);
        send_line(40, 0, 20, 63, 8'h96, 8'h3c, 8'hc3);
        send_line(0, 0, 63, 62, 8'hde, 8'had, 8'hbe);
        send_line(0, 0, 62, 63, 8'hef, 8'hca, 8'hfe);
        send_line(31, 32, 32, 31, 8'h10, 8'h20, 8'h40);
        send_line(1, 2, 3, 4, 8'h02, 8'h04, 8'h08);
        send_line(63, 0, 0, 1, 8'hfd, 8'hfb, 8'hf7);
        drain_pixels();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                w_set[ph] = $urandom_range(1, 64);
                h_set[ph] = $urandom_range(1, 64);
            end
            write_reg(CFG_IMAGE_WIDTH, CFG_W'(w_set[ph]));
            write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h_set[ph]));
            if (ph == 2) begin
                write_reg(CFG_SPARE_A, 7'h00);
                write_reg(CFG_SPARE_B, 7'h7f);
            end
            settings++;

            if (ph == 3) begin
                // long lines against a stalled result side: fill the queue
                @(posedge i_clk);
                hold_left = HOLD_CYCLES;
                repeat (16)
                    send_line(CW'($urandom_range(0, 10)), CW'($urandom),
                              CW'($urandom_range(50, 63)), CW'($urandom),
                              COLOR_W'($urandom), COLOR_W'($urandom),
                              COLOR_W'($urandom));
            end

            sent = 0;
            while (sent < LINES_PER_PHASE) begin
                burst = $urandom_range(1, 10);
                repeat (burst) begin
                    if (sent < LINES_PER_PHASE) begin
                        random_line();
                        sent++;
                    end
                end
                if ($urandom_range(0, 3) != 0)
                    idle_input($urandom_range(1, 8));
            end
            drain_pixels();
        end

        $display("covered %0d lines, %0d pixels over %0d size settings",
                 sb.lines, sb.checked, settings);
        $display("input stalled %0d cycles while the queue was full", in_stalls);
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
